>>> rtl/core/tloc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tloc_pkg;

    localparam int MAX_AXES  = 7;
    localparam int CNT_W     = $clog2(MAX_AXES + 1);
    localparam int EXTENT_W  = 24;
    localparam int STRIDE_W  = 24;
    localparam int REACH_W   = 52;
    localparam int PROD_W    = STRIDE_W + EXTENT_W + 1;
    localparam int VERDICT_W = 2;

    localparam logic [VERDICT_W-1:0] VERDICT_DISJOINT = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_OVERLAP  = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_ZERO_EXT = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_TOO_MANY = 2'd3;

    typedef struct packed {
        logic [EXTENT_W-1:0]        extent;
        logic signed [STRIDE_W-1:0] stride;
    } axis_t;

    // Chain control, common to every cell.
    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

    // Reach unit control from the sequencer.
    typedef struct packed {
        logic clear;
        logic check;
        logic add;
    } scan_ctrl_t;

    // Classification of the axis at the head of the chain.
    typedef struct packed {
        logic zero;
        logic skip;
        logic fail;
    } scan_stat_t;

    // True when axis a belongs strictly after axis b in the scan order:
    // ascending by absolute stride, then signed stride, then extent.
    function automatic logic sorts_after(input axis_t a, input axis_t b);
        logic [STRIDE_W:0] abs_a;
        logic [STRIDE_W:0] abs_b;
        abs_a = a.stride[STRIDE_W-1] ? -{a.stride[STRIDE_W-1], a.stride}
                                     : {1'b0, a.stride};
        abs_b = b.stride[STRIDE_W-1] ? -{b.stride[STRIDE_W-1], b.stride}
                                     : {1'b0, b.stride};
        if (abs_a != abs_b) begin
            return abs_a > abs_b;
        end else if (a.stride != b.stride) begin
            return a.stride > b.stride;
        end else begin
            return a.extent > b.extent;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/tensor_layout_overlap_check.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Contents
// s_axis   in         tdata[23:0] axis_extent, tdata[47:24] axis_stride, tlast last_axis
// m_axis   out        tdata[1:0] verdict (0 disjoint, 1 overlap, 2 zero extent, 3 too many)
//
// Axes are taken back to back while loading; each is sorted into a chain of cells
// on entry. After the last axis the chain drains from its head through the reach unit:
// an axis that needs a reach update passes through ST_CHECK and ST_ADD, a skipped axis
// through ST_CHECK alone, and ST_FINISH then hands over the verdict.
// Reset is synchronous and active low; it empties the chain and the output register.
// The verdict sits in an output register, so the next layout's axes are accepted
// while it waits; only a second verdict stalls until the first has been taken.

module tensor_layout_overlap_check (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // axis_extent [23:0], axis_stride [47:24]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // verdict [1:0], zeros above
);
    import tloc_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_ADD    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic [VERDICT_W-1:0]   verdict_reg, verdict_next;
    logic                   m_valid_reg, m_valid_next;
    logic [VERDICT_W-1:0]   m_data_reg, m_data_next;

    axis_t                  new_axis;
    axis_t                  cell_axis [MAX_AXES];
    logic                   cell_shift [MAX_AXES];
    logic                   cell_valid [MAX_AXES];
    cell_ctrl_t             cell_ctrl;
    scan_ctrl_t             scan_ctrl;
    scan_stat_t             scan_stat;
    logic                   in_xfer;
    logic                   has_room;
    logic                   last_in_chain;
    logic                   out_free;

    assign new_axis.extent = s_tdata[EXTENT_W-1:0];
    assign new_axis.stride = signed'(s_tdata[EXTENT_W +: STRIDE_W]);

    assign s_tready      = (state_reg == ST_LOAD);
    assign in_xfer       = s_tvalid && s_tready;
    assign has_room      = (count_reg < CNT_W'(MAX_AXES));
    assign last_in_chain = (count_reg == CNT_W'(1));
    assign out_free      = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8 - VERDICT_W){1'b0}}, m_data_reg};

    // The chain of cells, sorted ascending from the head at place zero.
    for (genvar i = 0; i < MAX_AXES; i++) begin : g_chain
        assign cell_valid[i] = (CNT_W'(i) < count_reg);
        if (i == 0) begin : g_head
            if (MAX_AXES > 1) begin : g_more
                tloc_cell u_cell (
                    .aclk       (aclk),
                    .ctrl       (cell_ctrl),
                    .cell_valid (cell_valid[i]),
                    .new_axis   (new_axis),
                    .left_axis  (new_axis),
                    .left_valid (1'b1),
                    .left_shift (1'b0),
                    .right_axis (cell_axis[i+1]),
                    .axis       (cell_axis[i]),
                    .shift      (cell_shift[i])
                );
            end else begin : g_single
                tloc_cell u_cell (
                    .aclk       (aclk),
                    .ctrl       (cell_ctrl),
                    .cell_valid (cell_valid[i]),
                    .new_axis   (new_axis),
                    .left_axis  (new_axis),
                    .left_valid (1'b1),
                    .left_shift (1'b0),
                    .right_axis (new_axis),
                    .axis       (cell_axis[i]),
                    .shift      (cell_shift[i])
                );
            end
        end else if (i == MAX_AXES - 1) begin : g_tail
            tloc_cell u_cell (
                .aclk       (aclk),
                .ctrl       (cell_ctrl),
                .cell_valid (cell_valid[i]),
                .new_axis   (new_axis),
                .left_axis  (cell_axis[i-1]),
                .left_valid (cell_valid[i-1]),
                .left_shift (cell_shift[i-1]),
                .right_axis (new_axis),
                .axis       (cell_axis[i]),
                .shift      (cell_shift[i])
            );
        end else begin : g_mid
            tloc_cell u_cell (
                .aclk       (aclk),
                .ctrl       (cell_ctrl),
                .cell_valid (cell_valid[i]),
                .new_axis   (new_axis),
                .left_axis  (cell_axis[i-1]),
                .left_valid (cell_valid[i-1]),
                .left_shift (cell_shift[i-1]),
                .right_axis (cell_axis[i+1]),
                .axis       (cell_axis[i]),
                .shift      (cell_shift[i])
            );
        end
    end

    tloc_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (scan_ctrl),
        .head    (cell_axis[0]),
        .stat    (scan_stat)
    );

    // Sequencer: load axes, then drain the chain through the reach unit.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        verdict_next = verdict_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        cell_ctrl    = '0;
        scan_ctrl    = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (in_xfer) begin
                    if (has_room) begin
                        cell_ctrl.insert = 1'b1;
                        count_next       = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        scan_ctrl.clear = 1'b1;
                        if (ovf_reg || !has_room) begin
                            verdict_next = VERDICT_TOO_MANY;
                            state_next   = ST_FINISH;
                        end else begin
                            state_next = ST_CHECK;
                        end
                    end
                end
            end
            ST_CHECK: begin
                if (scan_stat.zero) begin
                    verdict_next = VERDICT_ZERO_EXT;
                    state_next   = ST_FINISH;
                end else if (scan_stat.skip) begin
                    cell_ctrl.pop = 1'b1;
                    count_next    = count_reg - CNT_W'(1);
                    if (last_in_chain) begin
                        verdict_next = VERDICT_DISJOINT;
                        state_next   = ST_FINISH;
                    end
                end else if (scan_stat.fail) begin
                    verdict_next = VERDICT_OVERLAP;
                    state_next   = ST_FINISH;
                end else begin
                    scan_ctrl.check = 1'b1;
                    state_next      = ST_ADD;
                end
            end
            ST_ADD: begin
                scan_ctrl.add = 1'b1;
                cell_ctrl.pop = 1'b1;
                count_next    = count_reg - CNT_W'(1);
                if (last_in_chain) begin
                    verdict_next = VERDICT_DISJOINT;
                    state_next   = ST_FINISH;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = verdict_reg;
                    count_next   = '0;
                    ovf_next     = 1'b0;
                    state_next   = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        verdict_reg <= verdict_next;
        m_data_reg  <= m_data_next;
    end

    // The fill count never passes the length of the chain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_AXES))
        else $error("axis count beyond chain length");

    // The chain is never empty while the head is being judged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK || state_reg == ST_ADD) |-> (count_reg != '0))
        else $error("scan of an empty chain");

    // A reach update always follows a passing check.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD) |-> $past(state_reg == ST_CHECK))
        else $error("reach update without check");

    // A verdict leaving the sequencer is presented on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free) |=>
            (m_valid_reg && state_reg == ST_LOAD && count_reg == '0))
        else $error("verdict hand-over lost");

endmodule

`default_nettype wire

>>> rtl/core/tloc_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One place of the sorted axis chain. On insert it either keeps its axis,
// takes the new axis, or takes its left neighbour's axis; on pop it takes
// the right neighbour's axis so the chain drains towards the head.
module tloc_cell (
    input  wire logic               aclk,
    input  wire tloc_pkg::cell_ctrl_t ctrl,
    input  wire logic               cell_valid,
    input  wire tloc_pkg::axis_t    new_axis,
    input  wire tloc_pkg::axis_t    left_axis,
    input  wire logic               left_valid,
    input  wire logic               left_shift,
    input  wire tloc_pkg::axis_t    right_axis,
    output tloc_pkg::axis_t         axis,
    output logic                    shift
);
    import tloc_pkg::*;

    axis_t axis_reg;
    axis_t axis_next;
    logic  take;

    assign axis  = axis_reg;
    assign shift = cell_valid && sorts_after(axis_reg, new_axis);
    assign take  = (!cell_valid || shift) && left_valid && !left_shift;

    always_comb begin
        axis_next = axis_reg;
        if (ctrl.pop) begin
            axis_next = right_axis;
        end else if (ctrl.insert) begin
            if (left_shift) begin
                axis_next = left_axis;
            end else if (take) begin
                axis_next = new_axis;
            end
        end
    end

    always_ff @(posedge aclk) begin
        axis_reg <= axis_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/tloc_scan.sv
`timescale 1ns / 1ps
`default_nettype none

// Reach unit: classifies the head axis against the current reaches and
// grows the reach on the stride's side by stride * (extent - 1).
module tloc_scan (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire tloc_pkg::scan_ctrl_t ctrl,
    input  wire tloc_pkg::axis_t    head,
    output tloc_pkg::scan_stat_t    stat
);
    import tloc_pkg::*;

    logic signed [REACH_W-1:0] pos_reach_reg, pos_reach_next;
    logic signed [REACH_W-1:0] neg_reach_reg, neg_reach_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [REACH_W-1:0] stride_ext;
    logic signed [EXTENT_W:0]  span;
    logic                      positive;

    assign stride_ext = REACH_W'(head.stride);
    assign span       = signed'({1'b0, head.extent - EXTENT_W'(1)});
    assign positive   = (head.stride > 0);

    assign stat.zero = (head.extent == '0);
    assign stat.skip = (head.extent == EXTENT_W'(1));
    assign stat.fail = positive ? (stride_ext <= pos_reach_reg)
                                : (neg_reach_reg <= stride_ext);

    always_comb begin
        pos_reach_next = pos_reach_reg;
        neg_reach_next = neg_reach_reg;
        if (ctrl.clear) begin
            pos_reach_next = '0;
            neg_reach_next = '0;
        end else if (ctrl.add) begin
            if (positive) begin
                pos_reach_next = pos_reach_reg + REACH_W'(prod_reg);
            end else begin
                neg_reach_next = neg_reach_reg + REACH_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reach_reg <= '0;
            neg_reach_reg <= '0;
        end else begin
            pos_reach_reg <= pos_reach_next;
            neg_reach_reg <= neg_reach_next;
        end
    end

    // Both factors are widened to the full product width first.
    always_ff @(posedge aclk) begin
        if (ctrl.check) begin
            prod_reg <= PROD_W'(head.stride) * PROD_W'(span);
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/tensor_layout_overlap_check_tb.sv
`timescale 1ns / 1ps

module tensor_layout_overlap_check_tb;

    import tloc_pkg::*;

    // The idling patterns that the run steps through, one per phase.
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // Keeps a copy of the layout being loaded, works out the verdict that each
    // last-axis transfer must produce, and checks verdicts in arrival order.
    class overlap_board_t;
        axis_t                axes_held[$];
        bit                   spilled;
        logic [VERDICT_W-1:0] verdicts_due[$];
        int                   faults;

        function bit ranks_above(axis_t a, axis_t b);
            longint sa;
            longint sb;
            longint ma;
            longint mb;
            sa = $signed(a.stride);
            sb = $signed(b.stride);
            ma = (sa < 0) ? -sa : sa;
            mb = (sb < 0) ? -sb : sb;
            if (ma != mb) begin
                return ma > mb;
            end
            if (sa != sb) begin
                return sa > sb;
            end
            return a.extent > b.extent;
        endfunction

        function logic [VERDICT_W-1:0] judge_layout();
            axis_t  order[$];
            axis_t  held;
            longint up_reach;
            longint down_reach;
            longint s;
            longint e;
            int     j;
            if (spilled) begin
                return VERDICT_TOO_MANY;
            end
            order = axes_held;
            for (int i = 1; i < order.size(); i++) begin
                held = order[i];
                j = i;
                while (j > 0 && ranks_above(order[j-1], held)) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = held;
            end
            up_reach   = 0;
            down_reach = 0;
            foreach (order[i]) begin
                s = $signed(order[i].stride);
                e = order[i].extent;
                if (e == 0) begin
                    return VERDICT_ZERO_EXT;
                end
                if (e == 1) begin
                    continue;
                end
                if (s > 0) begin
                    if (s <= up_reach) begin
                        return VERDICT_OVERLAP;
                    end
                    up_reach += s * (e - 1);
                end else begin
                    if (down_reach <= s) begin
                        return VERDICT_OVERLAP;
                    end
                    down_reach += s * (e - 1);
                end
            end
            return VERDICT_DISJOINT;
        endfunction

        function void note_axis(axis_t a, bit last_mark);
            if (axes_held.size() < MAX_AXES) begin
                axes_held = {axes_held, a};
            end else begin
                spilled = 1'b1;
            end
            if (last_mark) begin
                verdicts_due = {verdicts_due, judge_layout()};
                axes_held.delete();
                spilled = 1'b0;
            end
        endfunction

        function void check_verdict(logic [7:0] word);
            logic [VERDICT_W-1:0] want;
            if (verdicts_due.size() == 0) begin
                $error("verdict %0d arrived with no verdict expected", word[1:0]);
                faults++;
                return;
            end
            want = verdicts_due.pop_front();
            if (word[1:0] !== want) begin
                $error("field verdict: expected %0d, actual %0d", want, word[1:0]);
                faults++;
            end
            if (word[7:2] !== 6'd0) begin
                $error("field m_tdata[7:2]: expected 0, actual %0h", word[7:2]);
                faults++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;     // axis_extent [23:0], axis_stride [47:24]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;     // verdict [1:0], zeros above

    overlap_board_t layout_board = new();

    // Idling controls. The percentages and the hold-off count are only ever
    // set just after a rising edge, and read (the count also run down) at the
    // falling edge, so the processes never race on them.
    int send_idle_pct;
    int recv_stall_pct;
    int stall_hold;
    int axes_sent;

    tensor_layout_overlap_check DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Both channels are observed at the rising edge. The block's registers
    // only move in the nonblocking region, so the values read here are those
    // that the handshake saw. Input transfers are noted first, although a
    // verdict can never leave in the same cycle as its own last axis.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                layout_board.note_axis(axis_t'({s_tdata[23:0], s_tdata[47:24]}), s_tlast);
            end
            if (m_tvalid && m_tready) begin
                layout_board.check_verdict(m_tdata);
            end
        end
    end

    // The receiver decides afresh at every falling edge. A pending hold-off
    // keeps m_tready low for its whole length, so that the output register
    // fills, the next layout loads behind it, and s_tready finally drops.
    always @(negedge aclk) begin
        if (stall_hold > 0) begin
            m_tready <= 1'b0;
            stall_hold = stall_hold - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic axis_t axis_of(input int ext, input int stp);
        axis_t a;
        a.extent = ext[23:0];
        a.stride = stp[23:0];
        return a;
    endfunction

    // Offers one axis from a falling edge and returns at the falling edge
    // after its transfer. tvalid stays high into the next axis unless the
    // sender chooses to idle first.
    task automatic offer_axis(input axis_t a, input bit last_mark);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {a.stride, a.extent};
        s_tlast  <= last_mark;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        @(negedge aclk);
        axes_sent++;
    endtask

    task automatic send_layout(input axis_t lay[$]);
        foreach (lay[i]) begin
            offer_axis(lay[i], i == lay.size() - 1);
        end
    endtask

    // The sender goes quiet across the phase change, so the axis that was
    // just taken is not offered a second time.
    task automatic set_phase(input idle_mode_t mode, input int hold_cycles);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        send_idle_pct  = (mode == IDLE_SENDER) ? 55 : (mode == IDLE_BOTH) ? 28 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 55 : (mode == IDLE_BOTH) ? 28 : 0;
        stall_hold     = hold_cycles;
        @(negedge aclk);
    endtask

    // Builds one random layout. Half are well-formed dense layouts, where each
    // stride just clears everything below it, so the scan walks all the way
    // through; some of these are nudged into overlap or given a zero extent.
    // The rest are too-long layouts, small random axes and full-range fields.
    task automatic random_layout();
        axis_t lay[$];
        axis_t swap;
        int    kind;
        int    n;
        int    span;
        int    ext;
        int    stp;
        int    k;
        kind = $urandom_range(0, 99);
        n    = (kind < 10) ? $urandom_range(MAX_AXES + 1, MAX_AXES + 3)
                           : $urandom_range(1, MAX_AXES);
        if (kind >= 10 && kind < 60) begin
            span = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                ext = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
                stp = $urandom_range(0, 1) ? -span : span;
                lay = {lay, axis_of(ext, stp)};
                span = span * ext + $urandom_range(0, 2);
            end
            // Pull one stride towards zero, which usually lands it inside the reach.
            if ($urandom_range(0, 3) == 0) begin
                k = $urandom_range(0, n - 1);
                stp = $signed(lay[k].stride);
                lay[k].stride = STRIDE_W'((stp > 0) ? stp - 1 : stp + 1);
            end
            if ($urandom_range(0, 19) == 0) begin
                lay[$urandom_range(0, n - 1)].extent = '0;
            end
        end else if (kind < 80) begin
            for (int i = 0; i < n; i++) begin
                ext = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
                stp = $urandom_range(0, 12) - 6;
                lay = {lay, axis_of(ext, stp)};
            end
        end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                ext = $urandom_range(0, 3) ? $urandom_range(0, 24'hFFFFFF)
                                           : $urandom_range(0, 8);
                lay = {lay, axis_of(ext, $urandom)};
            end
        end
        // Arrival order is shuffled; the block has to sort it out itself.
        for (int i = lay.size() - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            swap = lay[i];
            lay[i] = lay[k];
            lay[k] = swap;
        end
        send_layout(lay);
    endtask

    initial begin
        axis_t lay[$];
        int    target;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stall_hold     = 0;
        axes_sent      = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed layouts: a lone skipped axis, a zero extent, a zero stride
        // that fails and one that is skipped, a full layout at the field
        // extremes, one axis too many, a plain overlap, and a zero extent
        // that sorts behind an axis that has already failed.
        lay = '{axis_of(1, 1)};
        send_layout(lay);
        lay = '{axis_of(0, 3)};
        send_layout(lay);
        lay = '{axis_of(5, 0)};
        send_layout(lay);
        lay = '{axis_of(1, 0)};
        send_layout(lay);
        lay = '{axis_of(24'hFFFFFF, 8388607), axis_of(24'hFFFFFF, -8388608),
                axis_of(2, 1), axis_of(3, -1), axis_of(1, 5), axis_of(4, 2),
                axis_of(1, -7)};
        send_layout(lay);
        lay.delete();
        for (int i = 0; i <= MAX_AXES; i++) begin
            lay = {lay, axis_of(2, 1 << i)};
        end
        send_layout(lay);
        lay = '{axis_of(4, 1), axis_of(2, 3)};
        send_layout(lay);
        lay = '{axis_of(3, 0), axis_of(0, 5)};
        send_layout(lay);

        // Random phases of about two hundred axes each. The first phase runs
        // at full rate and opens with a long receiver hold-off.
        target = axes_sent;
        for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
            set_phase(idle_mode_t'(m), (m == IDLE_NONE) ? 400 : 0);
            target += 200;
            while (axes_sent < target) begin
                random_layout();
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // Drain: every verdict must arrive, then a margin longer than the
        // longest scan lets any stray transfer show itself.
        while (layout_board.verdicts_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);
        if (layout_board.faults == 0) begin
            $display("tensor_layout_overlap_check_tb: clean");
        end else begin
            $display("tensor_layout_overlap_check_tb: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, even with every stall at its worst.
    initial begin
        #1000000;
        $display("tensor_layout_overlap_check_tb: errors");
        $finish;
    end

endmodule
